// ===== hdl/tpq_pkg.sv =====
// shared constants and types for the track packet refresh queue
package tpq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int MAX_DATA_BYTES = 6;
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W          = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_FORGET = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  data_len;
        logic [6:0]  resend_count;
        logic        continuous;
        logic        high_priority;
        logic [7:0]  address_type;
        logic [15:0] address;
        logic [47:0] payload;
    } entry_t;

    // per-cycle shift command shared by all cells
    typedef struct packed {
        logic             load;       // apply this cycle
        logic [IDX_W-1:0] rm_pos;     // position removed (if rm)
        logic             rm;
        logic             put_front;
        logic             put_back;
        logic [CNT_W-1:0] back_pos;   // count after removal
        entry_t           new_entry;
    } shift_cmd_t;

endpackage

// ===== hdl/tpq_cell.sv =====
// one queue slot: holds an entry and compares its key
module tpq_cell
(
    input  logic                clk,
    input  logic [tpq_pkg::IDX_W-1:0] pos,
    input  tpq_pkg::shift_cmd_t cmd,
    input  tpq_pkg::entry_t     prev_entry,
    input  tpq_pkg::entry_t     next_entry,
    input  logic [23:0]         key,
    output tpq_pkg::entry_t     entry,
    output logic                hit
);
    import tpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   after_rm;

    assign entry = entry_reg;
    assign hit   = ({entry_reg.address_type, entry_reg.address} == key);

    always_comb
    begin
        entry_next = entry_reg;
        after_rm   = cmd.rm && (pos >= cmd.rm_pos);
        if (cmd.put_front)
        begin
            // shift right; with removal, cells past the hole hold their place
            if (pos == '0)
                entry_next = cmd.new_entry;
            else if (!(cmd.rm && (pos > cmd.rm_pos)))
                entry_next = prev_entry;
        end
        else
        begin
            if (after_rm)
                entry_next = next_entry;
            if (cmd.put_back && ({1'b0, pos} == cmd.back_pos))
                entry_next = cmd.new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            entry_reg <= entry_next;
    end

endmodule

// ===== hdl/track_packet_refresh_queue_core.sv =====
// top level of the track packet refresh queue
// Each beat is first registered; then every slot's key is compared in parallel and
// the row of slot cells is shifted in one step. A result then waits in an output
// register; the next beat is taken while it waits, and its processing is held off
// only while the previous result is still not taken. The input is stalled from the
// cycle after a beat is taken until that beat has been processed.
module track_packet_refresh_queue_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [7:0]  address_type,
    input  logic        high_priority,
    input  logic        continuous,
    input  logic [6:0]  resend_count,
    input  logic [2:0]  data_len,
    input  logic [47:0] payload,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] out_address,
    output logic [7:0]  out_address_type,
    output logic        out_high_priority,
    output logic        out_continuous,
    output logic [6:0]  out_resend_count,
    output logic [2:0]  out_data_len,
    output logic [47:0] out_payload,
    output logic [4:0]  occupancy
);
    import tpq_pkg::*;

    logic             busy_reg;
    logic [1:0]       kind_reg;
    entry_t           in_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ov_reg;
    logic [1:0]       st_reg, st_next;
    entry_t           oe_reg, oe_next;
    logic             have_next;

    entry_t           cells [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] hits;
    shift_cmd_t       cmd;
    entry_t           zero_e;
    logic [23:0]      key;

    logic             found;
    logic [IDX_W-1:0] fpos;
    logic [CNT_W-1:0] c1;
    entry_t           head, re;
    logic             accept;
    logic             fire;

    assign zero_e = '0;
    assign key    = {in_reg.address_type, in_reg.address};
    assign fire   = busy_reg && !(ov_reg && out_stall);
    assign in_stall = busy_reg;
    assign accept = in_valid && !busy_reg;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            tpq_cell u_cell
            (
                .clk        (clk),
                .pos        (IDX_W'(g)),
                .cmd        (cmd),
                .prev_entry ((g == 0) ? zero_e : cells[(g == 0) ? 0 : g - 1]),
                .next_entry ((g == QUEUE_DEPTH - 1) ? zero_e
                             : cells[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
                .key        (key),
                .entry      (cells[g]),
                .hit        (hits[g])
            );
        end
    endgenerate

    always_comb
    begin
        found = 1'b0;
        fpos  = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i] && (CNT_W'(i) < count_reg))
            begin
                found = 1'b1;
                fpos  = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.load   = fire;
        count_next = count_reg;
        st_next    = ST_OK;
        oe_next    = '0;
        have_next  = 1'b0;
        head       = cells[0];
        re         = head;
        c1         = count_reg;
        case (kind_reg)
            KIND_INSERT:
            begin
                cmd.rm     = found;
                cmd.rm_pos = fpos;
                c1         = found ? count_reg - 1'b1 : count_reg;
                cmd.new_entry = in_reg;
                if (in_reg.data_len > 3'(MAX_DATA_BYTES))
                    cmd.new_entry.data_len = 3'(MAX_DATA_BYTES);
                cmd.back_pos = c1;
                if (c1 == CNT_W'(QUEUE_DEPTH))
                    st_next = ST_FULL;
                else
                begin
                    cmd.put_front = in_reg.high_priority;
                    cmd.put_back  = !in_reg.high_priority;
                    c1 = c1 + 1'b1;
                end
                count_next = c1;
            end
            KIND_READ:
            begin
                if (count_reg == '0)
                    st_next = ST_MISS;
                else
                begin
                    have_next  = 1'b1;
                    cmd.rm     = 1'b1;
                    cmd.rm_pos = '0;
                    cmd.back_pos = count_reg - 1'b1;
                    c1 = count_reg - 1'b1;
                    if (head.continuous)
                    begin
                        cmd.put_back = 1'b1;
                        c1 = count_reg;
                    end
                    else if (head.resend_count != '0)
                    begin
                        re.resend_count = head.resend_count - 1'b1;
                        c1 = count_reg;
                        if (head.high_priority)
                            cmd.put_front = 1'b1;
                        else
                            cmd.put_back = 1'b1;
                    end
                    cmd.new_entry = re;
                    oe_next    = re;
                    count_next = c1;
                end
            end
            KIND_FORGET:
            begin
                cmd.rm     = found;
                cmd.rm_pos = fpos;
                if (found)
                    count_next = count_reg - 1'b1;
                else
                    st_next = ST_MISS;
            end
            default:
                count_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (fire)
                busy_reg <= 1'b0;
            if (fire)
                count_reg <= count_next;
            if (fire)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            in_reg   <= '{data_len, resend_count, continuous, high_priority,
                          address_type, address, payload};
        end
        if (fire)
        begin
            st_reg <= st_next;
            oe_reg <= have_next ? oe_next : '0;
        end
    end

    assign out_valid         = ov_reg;
    assign status            = st_reg;
    assign out_address       = oe_reg.address;
    assign out_address_type  = oe_reg.address_type;
    assign out_high_priority = oe_reg.high_priority;
    assign out_continuous    = oe_reg.continuous;
    assign out_resend_count  = oe_reg.resend_count;
    assign out_data_len      = oe_reg.data_len;
    assign out_payload       = oe_reg.payload;
    assign occupancy         = 5'(count_reg);

endmodule

// ===== hdl/tpq_checker.sv =====
// port-level checks for the track packet refresh queue
module tpq_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [4:0] occupancy,
    input logic [47:0] out_payload
);
    import tpq_pkg::*;

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= 5'(QUEUE_DEPTH)))
        else $error("occupancy above depth");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_OK) || (status == ST_MISS) || (status == ST_FULL)))
        else $error("bad status code");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (occupancy == 5'(QUEUE_DEPTH)))
        else $error("full status without full queue");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_payload)))
        else $error("stalled result changed");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a beat");

endmodule

bind track_packet_refresh_queue_core tpq_checker u_tpq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .occupancy  (occupancy),
    .out_payload(out_payload)
);
